// ===== hdl/crc16fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared constants, CRC-16 step function and the command/status bundles
// between the frame receiver controller and datapath.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

    localparam int          BYTE_W     = 8;
    localparam int          CNT_W      = 7;
    localparam int          IDX_W      = 6;
    localparam int          CRC_W      = 16;
    localparam int          OUT_DATA_W = 32;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_START   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    typedef struct packed {
        logic crc_init;
        logic take_type;
        logic take_len;
        logic take_data;
        logic take_crclo;
        logic emit_start;
        logic rd_issue;
        logic load_byte;
        logic load_empty;
        logic emit_advance;
    } dp_cmd_t;

    typedef struct packed {
        logic sync_first;
        logic sync_second;
        logic len_too_big;
        logic len_zero;
        logic fill_done;
        logic crc_match;
        logic held_len_zero;
        logic emit_last;
        logic out_free;
    } dp_status_t;

    // One byte through CRC-16, MSB first.
    function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16fr_ram.sv =====
// ----------------------------------------------------------------------------
// crc16fr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crc16fr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/crc16fr_dp.sv =====
// ----------------------------------------------------------------------------
// crc16fr_dp
// Datapath: header registers, running CRC, payload buffer, emit counter
// and the output register of the result stream.
// ----------------------------------------------------------------------------
module crc16fr_dp #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [crc16fr_pkg::BYTE_W-1:0]         in_byte,
    input  crc16fr_pkg::dp_cmd_t                   cmd,
    output crc16fr_pkg::dp_status_t                status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [crc16fr_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                                   out_last
);

    import crc16fr_pkg::*;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CMP_W  = 9;

    logic [CRC_W-1:0]      crc_reg;
    logic [BYTE_W-1:0]     type_reg;
    logic [CNT_W-1:0]      len_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [BYTE_W-1:0]     crclo_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic [CNT_W-1:0]      fill_plus;
    logic [CNT_W-1:0]      idx_plus;
    logic [BYTE_W-1:0]     rd_byte;
    logic                  wr_en;

    assign fill_plus = fill_reg + CNT_W'(1);
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign wr_en     = cmd.take_data && (CMP_W'(fill_reg) < CMP_W'(MAX_PAYLOAD));

    crc16fr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(fill_reg)),
        .wr_data (in_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (ADDR_W'(idx_reg)),
        .rd_data (rd_byte)
    );

    always_comb
    begin
        status.sync_first    = (in_byte == SYNC_FIRST);
        status.sync_second   = (in_byte == SYNC_SECOND);
        status.len_too_big   = (CMP_W'(in_byte) > CMP_W'(MAX_PAYLOAD));
        status.len_zero      = (in_byte == '0);
        status.fill_done     = (fill_plus >= len_reg);
        status.crc_match     = ({in_byte, crclo_reg} == crc_reg);
        status.held_len_zero = (len_reg == '0);
        status.emit_last     = (idx_plus == len_reg);
        status.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_START;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.crc_init)
            begin
                crc_reg <= CRC_START;
            end
            else if (cmd.take_type || cmd.take_len || cmd.take_data)
            begin
                crc_reg <= crc16_add(crc_reg, in_byte);
            end

            if (cmd.take_len)
            begin
                fill_reg <= '0;
            end
            else if (cmd.take_data)
            begin
                fill_reg <= fill_plus;
            end

            if (cmd.emit_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit_advance)
            begin
                idx_reg <= idx_plus;
            end

            if (cmd.load_byte || cmd.load_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_type)
        begin
            type_reg <= in_byte;
        end
        if (cmd.take_len)
        begin
            len_reg <= in_byte[CNT_W-1:0];
        end
        if (cmd.take_crclo)
        begin
            crclo_reg <= in_byte;
        end
        if (cmd.load_byte)
        begin
            out_data_reg <= {2'b00, 1'b1, rd_byte, idx_reg[IDX_W-1:0], len_reg, type_reg};
            out_last_reg <= status.emit_last;
        end
        else if (cmd.load_empty)
        begin
            out_data_reg <= {2'b00, 1'b0, 8'h00, 6'd0, 7'd0, type_reg};
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/crc16fr_ctrl.sv =====
// ----------------------------------------------------------------------------
// crc16fr_ctrl
// Controller: frame parse state machine and payload emit sequencer.
// ----------------------------------------------------------------------------
module crc16fr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  crc16fr_pkg::dp_status_t status,
    output crc16fr_pkg::dp_cmd_t    cmd
);

    import crc16fr_pkg::*;

    typedef enum logic [3:0] {
        HUNT,
        SYNC1,
        TYPE_B,
        LEN_B,
        DATA_B,
        CRCLO,
        CRCHI,
        EMIT_RD,
        EMIT_LOAD,
        EMIT_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   accept;

    assign accept = in_valid && in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            HUNT:
            begin
                if (accept && status.sync_first)
                begin
                    state_next = SYNC1;
                end
            end
            SYNC1:
            begin
                if (accept)
                begin
                    if (status.sync_second)
                    begin
                        cmd.crc_init = 1'b1;
                        state_next   = TYPE_B;
                    end
                    else if (!status.sync_first)
                    begin
                        state_next = HUNT;
                    end
                end
            end
            TYPE_B:
            begin
                if (accept)
                begin
                    cmd.take_type = 1'b1;
                    state_next    = LEN_B;
                end
            end
            LEN_B:
            begin
                if (accept)
                begin
                    if (status.len_too_big)
                    begin
                        state_next = HUNT;
                    end
                    else
                    begin
                        cmd.take_len = 1'b1;
                        state_next   = status.len_zero ? CRCLO : DATA_B;
                    end
                end
            end
            DATA_B:
            begin
                if (accept)
                begin
                    cmd.take_data = 1'b1;
                    if (status.fill_done)
                    begin
                        state_next = CRCLO;
                    end
                end
            end
            CRCLO:
            begin
                if (accept)
                begin
                    cmd.take_crclo = 1'b1;
                    state_next     = CRCHI;
                end
            end
            CRCHI:
            begin
                if (accept)
                begin
                    if (!status.crc_match)
                    begin
                        state_next = HUNT;
                    end
                    else if (status.held_len_zero)
                    begin
                        state_next = EMIT_EMPTY;
                    end
                    else
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = EMIT_RD;
                    end
                end
            end
            EMIT_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = EMIT_LOAD;
            end
            EMIT_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = HUNT;
                    end
                    else
                    begin
                        cmd.emit_advance = 1'b1;
                        state_next       = EMIT_RD;
                    end
                end
            end
            EMIT_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = HUNT;
                end
            end
            default:
            begin
                state_next = HUNT;
            end
        endcase
    end

    assign in_ready_next = (state_next != EMIT_RD) && (state_next != EMIT_LOAD)
                           && (state_next != EMIT_EMPTY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= HUNT;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== hdl/crc16_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Sync-framed byte stream receiver with CRC-16/CCITT-FALSE check.
//
// Input stream: one received byte per beat on s_axis. The parser hunts for
// 0xAA 0x55, reads type, length, payload and a little-endian CRC over type,
// length and payload. Header, payload and CRC beats are taken one per cycle.
// Output stream: one beat per payload byte of a frame whose CRC matched, or
// one empty beat for a zero-length frame; m_axis_tlast marks the final beat.
// Frames with a bad CRC or an oversized length produce no beats.
// Each result is read from the payload buffer (EMIT_RD), then loaded into the
// output register (EMIT_LOAD); the next read is issued only after that load.
// s_axis_tready stays low while a frame is sent out and rises again once the
// last beat is loaded.
// A stall on m_axis holds the output register and the emit sequencer.
// Reset clears the parser to the sync hunt and empties the output register;
// s_axis_tready is registered and rises in the cycle after reset is released.
// ----------------------------------------------------------------------------
module crc16_frame_receiver #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [crc16fr_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] frame_type, [14:8] frame_length, [20:15] payload_index,
    // [28:21] payload_byte, [29] payload_valid, [31:30] zero
    output logic [crc16fr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast
);

    import crc16fr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    crc16fr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crc16fr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    a_stall_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open while a frame is still being sent");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[29] |->
            m_axis_tlast && (m_axis_tdata[28:8] == '0))
        else $error("empty-frame beat carries data or is not last");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[29] |->
            ({1'b0, m_axis_tdata[20:15]} < m_axis_tdata[14:8]))
        else $error("payload index beyond frame length");

endmodule

// ===== sim/crc16_frame_receiver_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_frame_receiver_test
// Feeds sync-framed byte streams into the frame receiver and scores every
// output beat against an in-bench parser with its own CRC-16 calculation.
// The stimulus covers empty frames, repeated sync bytes, oversized lengths,
// bad CRCs and full-length payloads, followed by random frames mixed with
// noise. Both stream sides idle at random, except in a stretch of the random frames.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_test;
    import crc16fr_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int RANDOM_BYTES = 250;
    localparam int IDLE_PCT     = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        HUNT_AA,
        HUNT_55,
        GET_TYPE,
        GET_LEN,
        GET_DATA,
        GET_CRC_LO,
        GET_CRC_HI
    } rx_phase_t;

    typedef struct packed {
        logic [7:0] ftype;
        logic [6:0] flen;
        logic [5:0] idx;
        logic [7:0] data;
        logic       valid;
        logic       last;
    } frame_beat_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    rx_phase_t   rx_phase    = HUNT_AA;
    logic [7:0]  rx_type     = 8'h00;
    logic [6:0]  rx_len      = 7'd0;
    logic [6:0]  rx_fill     = 7'd0;
    logic [7:0]  rx_crc_lo   = 8'h00;
    logic [15:0] rx_crc      = CRC_START;
    logic [7:0]  rx_store [MAX_LEN];

    frame_beat_t expected_beats [$];
    logic [7:0]  tx_payload [MAX_LEN];

    bit          idle_on        = 1'b1;
    int          bytes_sent     = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    crc16_frame_receiver #(
        .MAX_PAYLOAD(MAX_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !(idle_on && ($urandom_range(99) < IDLE_PCT));
    end

    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic rx_return_to_hunt();
        rx_phase  = HUNT_AA;
        rx_type   = 8'h00;
        rx_len    = 7'd0;
        rx_fill   = 7'd0;
        rx_crc_lo = 8'h00;
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        frame_beat_t beat;
        case (rx_phase)
            HUNT_55:
            begin
                if (b == SYNC_SECOND)
                begin
                    rx_phase = GET_TYPE;
                    rx_crc   = CRC_START;
                end
                else if (b != SYNC_FIRST)
                begin
                    rx_phase = HUNT_AA;
                end
            end
            GET_TYPE:
            begin
                rx_type  = b;
                rx_crc   = crc_ccitt_step(rx_crc, b);
                rx_phase = GET_LEN;
            end
            GET_LEN:
            begin
                if (b > MAX_LEN)
                begin
                    rx_return_to_hunt();
                end
                else
                begin
                    rx_len   = b[6:0];
                    rx_crc   = crc_ccitt_step(rx_crc, b);
                    rx_fill  = 7'd0;
                    rx_phase = (b == 8'h00) ? GET_CRC_LO : GET_DATA;
                end
            end
            GET_DATA:
            begin
                if (rx_fill < MAX_LEN)
                begin
                    rx_store[rx_fill[5:0]] = b;
                end
                rx_crc  = crc_ccitt_step(rx_crc, b);
                rx_fill = rx_fill + 7'd1;
                if (rx_fill >= rx_len)
                begin
                    rx_phase = GET_CRC_LO;
                end
            end
            GET_CRC_LO:
            begin
                rx_crc_lo = b;
                rx_phase  = GET_CRC_HI;
            end
            GET_CRC_HI:
            begin
                if ({b, rx_crc_lo} == rx_crc)
                begin
                    if (rx_len == 7'd0)
                    begin
                        beat = '{ftype: rx_type, flen: 7'd0, idx: 6'd0, data: 8'h00,
                                 valid: 1'b0, last: 1'b1};
                        expected_beats.push_back(beat);
                    end
                    else
                    begin
                        for (int i = 0; i < rx_len && i < MAX_LEN; i++)
                        begin
                            beat.ftype = rx_type;
                            beat.flen  = rx_len;
                            beat.idx   = i[5:0];
                            beat.data  = rx_store[i];
                            beat.valid = 1'b1;
                            beat.last  = (i + 1 == rx_len);
                            expected_beats.push_back(beat);
                        end
                    end
                end
                rx_return_to_hunt();
            end
            default:
            begin
                rx_phase = (b == SYNC_FIRST) ? HUNT_55 : HUNT_AA;
            end
        endcase
    endtask

    always @(negedge clk)
    begin : score_beat
        frame_beat_t got;
        frame_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ftype = m_axis_tdata[7:0];
            got.flen  = m_axis_tdata[14:8];
            got.idx   = m_axis_tdata[20:15];
            got.data  = m_axis_tdata[28:21];
            got.valid = m_axis_tdata[29];
            got.last  = m_axis_tlast;
            if (expected_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected beat type=%h len=%0d idx=%0d data=%h valid=%b last=%b",
                             $realtime, got.ftype, got.flen, got.idx, got.data,
                             got.valid, got.last);
                end
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.ftype !== want.ftype || got.flen !== want.flen ||
                    got.idx !== want.idx || got.data !== want.data ||
                    got.valid !== want.valid || got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: beat mismatch expected type=%h len=%0d idx=%0d data=%h valid=%b last=%b",
                                 $realtime, want.ftype, want.flen, want.idx, want.data,
                                 want.valid, want.last);
                        $display("%0t:                actual type=%h len=%0d idx=%0d data=%h valid=%b last=%b",
                                 $realtime, got.ftype, got.flen, got.idx, got.data,
                                 got.valid, got.last);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (idle_on && ($urandom_range(99) < IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(negedge clk);
        end
        while (!s_axis_tready);
        @(posedge clk);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic fill_payload(input int len);
        for (int i = 0; i < len; i++)
        begin
            tx_payload[i] = 8'($urandom_range(255));
        end
    endtask

    task automatic send_frame(input logic [7:0] ftype, input int len, input bit bad_crc);
        logic [15:0] crc;
        crc = CRC_START;
        crc = crc_ccitt_step(crc, ftype);
        crc = crc_ccitt_step(crc, len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            crc = crc_ccitt_step(crc, tx_payload[i]);
        end
        if (bad_crc)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(ftype);
        send_byte(len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            send_byte(tx_payload[i]);
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
    endtask

    task automatic test_empty_frame();
        send_frame(8'h00, 0, 1'b0);
        send_frame(8'hFF, 0, 1'b0);
    endtask

    task automatic test_repeated_sync();
        send_byte(SYNC_FIRST);
        send_byte(8'h12);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        fill_payload(1);
        send_frame(8'h3C, 1, 1'b0);
    endtask

    task automatic test_oversize_length();
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h21);
        send_byte(8'd65);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h22);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h00);
        send_byte(8'hFF);
        fill_payload(2);
        send_frame(8'hC3, 2, 1'b0);
    endtask

    task automatic test_crc_mismatch();
        fill_payload(2);
        send_frame(8'h81, 2, 1'b1);
        send_frame(8'h81, 0, 1'b1);
    endtask

    task automatic test_max_length();
        fill_payload(MAX_LEN);
        tx_payload[0]         = 8'h00;
        tx_payload[MAX_LEN-1] = 8'hFF;
        send_frame(8'h5A, MAX_LEN, 1'b0);
        fill_payload(MAX_LEN - 1);
        send_frame(8'hA5, MAX_LEN - 1, 1'b0);
    endtask

    task automatic test_random_frames();
        int start;
        int pick;
        int len;
        int noise;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            idle_on = !((bytes_sent - start >= 150) && (bytes_sent - start < 260));
            pick    = $urandom_range(99);
            if ($urandom_range(99) < 70)
            begin
                len = $urandom_range(8);
            end
            else if ($urandom_range(99) < 67)
            begin
                len = $urandom_range(32, 9);
            end
            else
            begin
                len = $urandom_range(MAX_LEN, 33);
            end
            fill_payload(len);
            if (pick < 70)
            begin
                send_frame(8'($urandom_range(255)), len, 1'b0);
            end
            else if (pick < 80)
            begin
                send_frame(8'($urandom_range(255)), len, 1'b1);
            end
            else if (pick < 87)
            begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255, MAX_LEN + 1)));
            end
            else if (pick < 93)
            begin
                send_byte(SYNC_FIRST);
                if ($urandom_range(1))
                begin
                    send_byte(SYNC_FIRST);
                end
                else
                begin
                    send_byte(8'($urandom_range(84, 0)));
                end
                send_frame(8'($urandom_range(255)), len, 1'b0);
            end
            else
            begin
                noise = $urandom_range(4, 1);
                repeat (noise)
                begin
                    send_byte(8'($urandom_range(255)));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_frame();
        test_repeated_sync();
        test_oversize_length();
        test_crc_mismatch();
        test_max_length();
        test_random_frames();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== crc16_frame_receiver.f =====
hdl/crc16fr_pkg.sv
hdl/crc16fr_ram.sv
hdl/crc16fr_dp.sv
hdl/crc16fr_ctrl.sv
hdl/crc16_frame_receiver.sv
sim/crc16_frame_receiver_test.sv
